@@ rtl/mmp_pkg.sv @@
// Shared types and constants for the MIDI message parser.
// Standalone package with no dependencies.
`default_nettype none

package mmp_pkg;

	localparam int LED_COUNT = 4;
	localparam int LED_W     = (LED_COUNT > 4) ? LED_COUNT : 4;

	localparam logic [6:0] LED_BASE_RESET = 7'd36;

	localparam logic [3:0] SYS_NIBBLE = 4'hf;

	typedef enum logic [2:0] {
		KIND_NOTE_OFF   = 3'd0,
		KIND_NOTE_ON    = 3'd1,
		KIND_KEY_PRESS  = 3'd2,
		KIND_CONTROL    = 3'd3,
		KIND_PROGRAM    = 3'd4,
		KIND_CHAN_PRESS = 3'd5,
		KIND_BEND       = 3'd6,
		KIND_SYSTEM     = 3'd7
	} msg_kind_t;

	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE  = 2'd1;
	localparam logic [1:0] NEED_TWO  = 2'd2;

	function automatic logic [1:0] data_len(input msg_kind_t kind);
		logic [1:0] len;
		unique case (kind)
			KIND_PROGRAM, KIND_CHAN_PRESS: len = NEED_ONE;
			default:                       len = NEED_TWO;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ rtl/midi_message_parser.sv @@
// MIDI byte-stream parser: input register, parse logic, result register.
// Depends on mmp_pkg for message kinds, LED count and data lengths.
`default_nettype none

// Takes one MIDI byte per clock and emits a finished channel or system
// message once its last byte has passed the input register and then the
// result register. The rate is one byte per clock while the result side
// takes its requests; in_stall rises only when the input and result
// registers are both full and the result is stalled. Running state
// (pending kind, channel, byte count, held data byte, LED flags) is
// updated as each byte leaves the input register. The user must write
// led_base_q through cfg_wr_en/cfg_wr_data only while idle; not enforced.
module midi_message_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [6:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      msg_kind,
	output logic [3:0]      channel_num,
	output logic [3:0]      system_type,
	output logic [6:0]      first_data,
	output logic [6:0]      second_data,
	output logic [3:0]      led_bits
);
	import mmp_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [6:0]       led_base_q;
	msg_kind_t        pend_kind_q;
	logic [3:0]       pend_chan_q;
	logic [1:0]       need_q;
	logic [6:0]       held_q;
	logic [LED_W-1:0] led_state_q;

	logic             out_valid_q;
	msg_kind_t        kind_q;
	logic [3:0]       chan_q;
	logic [3:0]       sys_q;
	logic [6:0]       d1_q;
	logic [6:0]       d2_q;
	logic [3:0]       leds_q;

	logic             produce;
	logic             advance;
	logic             take_s1;
	logic             in_accept;
	msg_kind_t        r_kind;
	logic [3:0]       r_chan;
	logic [3:0]       r_sys;
	logic [6:0]       r_d1;
	logic [6:0]       r_d2;
	msg_kind_t        n_pend_kind;
	logic [3:0]       n_pend_chan;
	logic [1:0]       n_need;
	logic [6:0]       n_held;
	logic [LED_W-1:0] n_leds;
	logic [LED_W-1:0] led_mask;
	logic [7:0]       key_off;
	logic             key_ge;

	always_comb begin
		key_ge  = r_d1 >= led_base_q;
		key_off = {1'b0, r_d1} - {1'b0, led_base_q};
		for (int i = 0; i < LED_W; i++) begin
			led_mask[i] = (i < LED_COUNT) && key_ge && (key_off == 8'(i));
		end
	end

	always_comb begin
		produce     = 1'b0;
		r_kind      = KIND_SYSTEM;
		r_chan      = '0;
		r_sys       = '0;
		r_d1        = '0;
		r_d2        = '0;
		n_pend_kind = pend_kind_q;
		n_pend_chan = pend_chan_q;
		n_need      = need_q;
		n_held      = held_q;
		n_leds      = led_state_q;
		if (byte_s1[7]) begin
			n_held = '0;
			if (byte_s1[7:4] == SYS_NIBBLE) begin
				produce = 1'b1;
				r_sys   = byte_s1[3:0];
				n_need  = NEED_NONE;
			end else begin
				n_pend_kind = msg_kind_t'(byte_s1[6:4]);
				n_pend_chan = byte_s1[3:0];
				n_need      = data_len(msg_kind_t'(byte_s1[6:4]));
			end
		end else if (need_q == NEED_TWO) begin
			n_held = byte_s1[6:0];
			n_need = NEED_ONE;
		end else if (need_q == NEED_ONE) begin
			produce = 1'b1;
			r_kind  = pend_kind_q;
			r_chan  = pend_chan_q;
			if (data_len(pend_kind_q) == NEED_TWO) begin
				r_d1 = held_q;
				r_d2 = byte_s1[6:0];
			end else begin
				r_d1 = byte_s1[6:0];
			end
			if (pend_kind_q == KIND_NOTE_ON) begin
				n_leds = led_state_q | led_mask;
			end else if (pend_kind_q == KIND_NOTE_OFF) begin
				n_leds = led_state_q & ~led_mask;
			end
			n_need = NEED_NONE;
			n_held = '0;
		end
	end

	assign advance   = !(valid_s1 && produce && out_valid_q && out_stall);
	assign take_s1   = valid_s1 && advance;
	assign in_stall  = !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			led_base_q  <= LED_BASE_RESET;
			pend_kind_q <= KIND_NOTE_OFF;
			pend_chan_q <= '0;
			need_q      <= NEED_NONE;
			held_q      <= '0;
			led_state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				led_base_q <= cfg_wr_data;
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				pend_kind_q <= n_pend_kind;
				pend_chan_q <= n_pend_chan;
				need_q      <= n_need;
				held_q      <= n_held;
				led_state_q <= n_leds;
			end
			if (take_s1 && produce) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
		if (take_s1 && produce) begin
			kind_q <= r_kind;
			chan_q <= r_chan;
			sys_q  <= r_sys;
			d1_q   <= r_d1;
			d2_q   <= r_d2;
			leds_q <= n_leds[3:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign msg_kind    = kind_q;
	assign channel_num = chan_q;
	assign system_type = sys_q;
	assign first_data  = d1_q;
	assign second_data = d2_q;
	assign led_bits    = leds_q;

	a_need_range: assert property (@(posedge clk) disable iff (!arst_n)
		need_q != 2'd3)
		else $error("byte count out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("stall with a free register");

	a_sys_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && byte_s1[7:4] == SYS_NIBBLE) |=> (need_q == NEED_NONE))
		else $error("system byte left a message pending");

	a_sys_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_SYSTEM) |->
		(chan_q == 4'd0 && d1_q == 7'd0 && d2_q == 7'd0))
		else $error("system message carries channel data");

endmodule

`default_nettype wire

@@ tb/tb_midi_message_parser.sv @@
// Self-checking testbench for midi_message_parser: directed and random MIDI byte
// streams, random idling on both sides and a long output hold-off.
// Depends on mmp_pkg and the midi_message_parser RTL only.
module tb_midi_message_parser;
	import mmp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		msg_kind_t  kind;
		logic [3:0] chan;
		logic [3:0] sys;
		logic [6:0] d1;
		logic [6:0] d2;
		logic [3:0] leds;
	} midi_msg_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] msg_kind;
	logic [3:0] channel_num;
	logic [3:0] system_type;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [3:0] led_bits;

	midi_msg_t        expected_msgs[$];
	logic [7:0]       pend_status;
	logic [1:0]       bytes_left;
	logic [6:0]       held_byte;
	logic [LED_W-1:0] led_flags;
	logic [6:0]       base_key;

	int  errors;
	int  cycle_count;
	int  idle_pct;
	int  stall_pct;
	int  hold_left;
	bit  hold_req;

	midi_message_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.msg_kind    (msg_kind),
		.channel_num (channel_num),
		.system_type (system_type),
		.first_data  (first_data),
		.second_data (second_data),
		.led_bits    (led_bits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		errors++;
	endtask

	// Track parser state and queue the message each byte completes.
	task automatic parse_byte(input logic [7:0] b);
		midi_msg_t m;
		msg_kind_t k;
		int        off;
		m = '0;
		k = msg_kind_t'(pend_status[6:4]);
		if (b[7]) begin
			if (b[7:4] == SYS_NIBBLE) begin
				pend_status = '0;
				bytes_left  = NEED_NONE;
				held_byte   = '0;
				m.kind = KIND_SYSTEM;
				m.sys  = b[3:0];
				m.leds = led_flags[3:0];
				expected_msgs.push_back(m);
			end else begin
				pend_status = b;
				bytes_left  = (b[6:4] == KIND_PROGRAM || b[6:4] == KIND_CHAN_PRESS) ?
					NEED_ONE : NEED_TWO;
				held_byte   = '0;
			end
		end else if (bytes_left == NEED_TWO) begin
			held_byte  = b[6:0];
			bytes_left = NEED_ONE;
		end else if (bytes_left == NEED_ONE) begin
			m.kind = k;
			m.chan = pend_status[3:0];
			if (k == KIND_PROGRAM || k == KIND_CHAN_PRESS) begin
				m.d1 = b[6:0];
			end else begin
				m.d1 = held_byte;
				m.d2 = b[6:0];
			end
			off = int'(m.d1) - int'(base_key);
			if (off >= 0 && off < LED_COUNT) begin
				if (k == KIND_NOTE_ON)
					led_flags[off] = 1'b1;
				else if (k == KIND_NOTE_OFF)
					led_flags[off] = 1'b0;
			end
			m.leds = led_flags[3:0];
			pend_status = '0;
			bytes_left  = NEED_NONE;
			held_byte   = '0;
			expected_msgs.push_back(m);
		end
	endtask

	// Called at a falling edge; returns at a falling edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_byte(b);
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_msgs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_base_key(input logic [6:0] key);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= key;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		base_key = key;
	endtask

	// Mostly well-formed messages; some noise and truncated messages.
	task automatic send_random_message(output int nbytes);
		logic [2:0] k;
		logic [6:0] key;
		logic [7:0] b;
		int         len;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			send_byte(8'($urandom_range(0, 255)));
			nbytes = 1;
			return;
		end
		k = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
		if (k == KIND_SYSTEM) begin
			send_byte({SYS_NIBBLE, 4'($urandom_range(0, 15))});
			nbytes = 1;
			return;
		end
		send_byte({1'b1, k, 4'($urandom_range(0, 15))});
		len = (k == KIND_PROGRAM || k == KIND_CHAN_PRESS) ? 1 : 2;
		if (roll < 16)
			len--;
		for (int i = 0; i < len; i++) begin
			if (i == 0 && $urandom_range(0, 1) == 1) begin
				key = base_key + 7'($urandom_range(0, 5)) - 7'd1;
				b   = {1'b0, key};
			end else begin
				b = {1'b0, 7'($urandom_range(0, 127))};
			end
			send_byte(b);
		end
		nbytes = len + 1;
	endtask

	task automatic test_message_kinds;
		send_bytes('{8'h55,
			8'h90, 8'h24, 8'h00,
			8'h8f, 8'h24, 8'h7f,
			8'h91, 8'h28, 8'h40,
			8'ha5, 8'h7f, 8'h7f,
			8'hb3, 8'h07, 8'h40,
			8'hc9, 8'h7f,
			8'hda, 8'h00,
			8'he1, 8'h00, 8'h7f,
			8'hf0, 8'hff});
	endtask

	task automatic test_stray_and_abandon;
		send_bytes('{8'h9e, 8'h28, 8'hc0, 8'h05,
			8'h90, 8'h30, 8'hf8,
			8'h33});
	endtask

	task automatic test_led_window;
		write_base_key(7'd0);
		send_bytes('{8'h90, 8'h00, 8'h10, 8'h90, 8'h03, 8'h10, 8'h80, 8'h00, 8'h10});
		write_base_key(7'd124);
		send_bytes('{8'h90, 8'h7f, 8'h10, 8'h90, 8'h7b, 8'h10, 8'h80, 8'h7f, 8'h00});
	endtask

	task automatic test_random_stream;
		int sent;
		int nb;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_base_key(7'd0);
				1: write_base_key(7'd124);
				default: write_base_key(7'($urandom_range(0, 124)));
			endcase
			idle_pct  = (p == 2) ? 0 : 24;
			stall_pct = (p == 2) ? 0 : 24;
			sent = 0;
			while (sent < 200) begin
				send_random_message(nb);
				sent += nb;
			end
		end
		idle_pct  = 24;
		stall_pct = 24;
	endtask

	task automatic test_backpressure;
		drain();
		idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_bytes('{{4'hc, 4'(i)}, 8'(i)});
		idle_pct = 24;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		midi_msg_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_msgs.size() == 0) begin
				report_mismatch($sformatf("unexpected message kind %0d", msg_kind));
			end else begin
				want = expected_msgs.pop_front();
				if (msg_kind !== want.kind)
					report_mismatch($sformatf("msg_kind %0d, want %0d", msg_kind, want.kind));
				if (channel_num !== want.chan)
					report_mismatch($sformatf("channel_num %0d, want %0d", channel_num,
						want.chan));
				if (system_type !== want.sys)
					report_mismatch($sformatf("system_type %0d, want %0d", system_type,
						want.sys));
				if (first_data !== want.d1)
					report_mismatch($sformatf("first_data %0d, want %0d", first_data, want.d1));
				if (second_data !== want.d2)
					report_mismatch($sformatf("second_data %0d, want %0d", second_data,
						want.d2));
				if (led_bits !== want.leds)
					report_mismatch($sformatf("led_bits %b, want %b", led_bits, want.leds));
			end
		end
	end

	initial begin
		errors      = 0;
		cycle_count = 0;
		idle_pct    = 24;
		stall_pct   = 24;
		hold_req    = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		rx_byte     = '0;
		pend_status = '0;
		bytes_left  = NEED_NONE;
		held_byte   = '0;
		led_flags   = '0;
		base_key    = LED_BASE_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_message_kinds();
		test_stray_and_abandon();
		test_led_window();
		test_random_stream();
		test_backpressure();
		drain();

		if (expected_msgs.size() != 0)
			report_mismatch($sformatf("%0d messages never arrived", expected_msgs.size()));
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/mmp_pkg.sv
rtl/midi_message_parser.sv
tb/tb_midi_message_parser.sv
